// ===== sv/gtg_pd_pkg.sv =====
// Types, constants and helper functions for the go-to-goal PD controller.
// No dependencies; imported by go_to_goal_pd_controller_unit.
package gtg_pd_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int CFG_IDX_W           = 4;
    localparam int CFG_DATA_W          = 24;
    localparam int GAIN_W              = 24;
    localparam int LIM_W               = 15;

    // 360 degrees in 1/64 degree, and half of it for index rounding
    localparam logic [14:0] TURN_UNITS = 15'd23040;
    localparam logic [14:0] TURN_HALF  = 15'd11520;
    // 23040 = 45 * 512: shift by 9, then multiply by ceil(2^26 / 45)
    localparam logic [20:0] RECIP_45   = 21'd1491309;
    localparam int          RECIP_SH   = 26;
    // ceil(2^18 / 5), exact for operands below 2^18
    localparam logic [16:0] RECIP_5    = 17'd52429;
    localparam int          RECIP5_SH  = 18;
    localparam logic [63:0] PI_Q30     = 64'd3373259426;

    localparam logic [23:0] RST_HEAD_P = 24'd8389;
    localparam logic [23:0] RST_HEAD_I = 24'd0;
    localparam logic [23:0] RST_HEAD_D = 24'd8389;
    localparam logic [23:0] RST_FWD    = 24'd629146;
    localparam logic [23:0] RST_LAT    = 24'd629146;
    localparam logic [14:0] RST_LIMIT  = 15'd2048;
    localparam logic [14:0] RST_WRAP   = 15'd19200;
    localparam logic [14:0] RST_ALIGN  = 15'd640;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAD_P = 4'd0,
        CFG_HEAD_I = 4'd1,
        CFG_HEAD_D = 4'd2,
        CFG_FWD    = 4'd3,
        CFG_LAT    = 4'd4,
        CFG_LIMIT  = 4'd5,
        CFG_WRAP   = 4'd6,
        CFG_ALIGN  = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic signed [15:0] goal_heading;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] heading;
    } t_in;

    typedef struct packed {
        logic signed [15:0] turn_rate;
        logic signed [15:0] forward_cmd;
        logic signed [15:0] lateral_cmd;
        logic               aligned;
    } t_out;

    // First-quadrant sine in Q14, Taylor series to x^13 evaluated in Q30.
    // Elaboration only: builds the constant table.
    function automatic logic [14:0] sine_q14_first(input int k, input int bits);
        logic [63:0] one;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        one = 64'd1 << 30;
        x   = (64'd2 * PI_Q30 * 64'(k)) >> bits;
        x2  = (x * x) >> 30;
        t   = one;
        t   = one - ((x2 * t) >> 30) / 156;
        t   = one - ((x2 * t) >> 30) / 110;
        t   = one - ((x2 * t) >> 30) / 72;
        t   = one - ((x2 * t) >> 30) / 42;
        t   = one - ((x2 * t) >> 30) / 20;
        t   = one - ((x2 * t) >> 30) / 6;
        t   = (x * t) >> 30;
        t   = (t + 64'd32768) >> 16;
        return t[14:0];
    endfunction

    function automatic logic signed [15:0] clamp16(input logic signed [47:0] v,
                                                  input logic [LIM_W-1:0] lim);
        logic signed [47:0] l;
        l = $signed({33'd0, lim});
        if (v > l) begin
            return $signed({1'b0, lim});
        end else if (v < -l) begin
            return -$signed({1'b0, lim});
        end
        return v[15:0];
    endfunction

endpackage

// ===== sv/go_to_goal_pd_controller_unit.sv =====
// Go-to-goal PD controller: heading PD term plus robot-frame translation.
// Depends on gtg_pd_pkg (types, constants, sine generator, clamp).
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  input   | in        | i_in_valid / o_in_stall   | i_in_data  (t_in)
//  output  | out       | o_out_valid / i_out_stall | o_out_data (t_out)
//  config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request steps through eleven sequencer states on the single shared 35x26
// multiplier and then loads the result register; the next request is taken
// after that load at the earliest.
// o_in_stall is high from acceptance until the result is loaded into the
// output register; a held result stalls the last state only.
// Synchronous active-low reset restores the register defaults and clears
// the previous heading error. Configuration is always ready.
module go_to_goal_pd_controller_unit #(
    parameter int SINE_TABLE_BITS = gtg_pd_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  gtg_pd_pkg::t_in                     i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output gtg_pd_pkg::t_out                    o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gtg_pd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gtg_pd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gtg_pd_pkg::*;

    localparam int B    = SINE_TABLE_BITS;
    localparam int TblQ = 1 << (B - 2);
    localparam int WW   = B + 6;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_TURN_P = 12'b000000000010,
        S_TURN_D = 12'b000000000100,
        S_TURN_R = 12'b000000001000,
        S_LOOK   = 12'b000000010000,
        S_FE_C   = 12'b000000100000,
        S_FE_S   = 12'b000001000000,
        S_LE_C   = 12'b000010000000,
        S_LE_S   = 12'b000100000000,
        S_FWD    = 12'b001000000000,
        S_LAT    = 12'b010000000000,
        S_DONE   = 12'b100000000000
    } t_state;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2,
        ACC_SUB  = 2'd3
    } t_acc_op;

    // constant quarter-wave table
    logic [14:0] w_qsin [TblQ+1];
    for (genvar g = 0; g <= TblQ; g++) begin : g_qsin
        assign w_qsin[g] = sine_q14_first(g, B);
    end

    t_state r_state, n_state;
    logic [GAIN_W-1:0] r_hp, r_hi, r_hd, r_fg, r_lg;
    logic [LIM_W-1:0]  r_lim, r_wrap, r_align;
    logic signed [16:0] r_last, n_last;
    logic signed [16:0] r_e, n_e;
    logic signed [17:0] r_diff, n_diff;
    logic signed [16:0] r_ex, n_ex, r_ey, n_ey;
    logic [15:0]        r_abs_e, n_abs_e;
    logic [WW-1:0]      r_w, n_w;
    logic signed [60:0] r_acc, n_acc;
    logic signed [15:0] r_turn, n_turn;
    logic signed [15:0] r_sn, n_sn, r_cs, n_cs;
    logic signed [32:0] r_fe, n_fe, r_le, n_le;
    logic signed [15:0] r_fc, n_fc, r_lc, n_lc;
    logic               r_out_valid, n_out_valid;
    t_out               r_out, n_out;
    // pending flag: final step of the request still to be written out
    logic               r_lc_pend, n_lc_pend;

    logic signed [34:0] w_mul_a;
    logic signed [25:0] w_mul_b;
    logic signed [60:0] w_prod;
    t_acc_op            w_acc_op;

    assign w_prod = w_mul_a * w_mul_b;

    always_comb begin
        logic signed [16:0] hs;
        logic signed [16:0] hm17;
        logic [14:0]        hm;
        logic [14+B:0]      hv;
        logic [B-1:0]       idx, cidx;
        logic [B-3:0]       r0, r1;
        logic [14:0]        v0, v1;
        logic signed [47:0] tr;
        logic [14:0]        aturn;
        logic [16:0]        rx;
        logic [13:0]        q;
        logic signed [15:0] tfin;
        logic               aligned;

        n_state     = r_state;
        n_last      = r_last;
        n_e         = r_e;
        n_diff      = r_diff;
        n_ex        = r_ex;
        n_ey        = r_ey;
        n_abs_e     = r_abs_e;
        n_w         = r_w;
        n_turn      = r_turn;
        n_sn        = r_sn;
        n_cs        = r_cs;
        n_fe        = r_fe;
        n_le        = r_le;
        n_fc        = r_fc;
        n_lc        = r_lc;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_acc_op    = ACC_HOLD;

        // heading reduced into one turn, then scaled towards a table index
        hs = 17'(i_in_data.heading);
        if (hs < -$signed({2'b0, TURN_UNITS})) begin
            hm17 = hs + $signed({1'b0, TURN_UNITS, 1'b0});
        end else if (hs < 0) begin
            hm17 = hs + $signed({2'b0, TURN_UNITS});
        end else if (hs >= $signed({2'b0, TURN_UNITS})) begin
            hm17 = hs - $signed({2'b0, TURN_UNITS});
        end else begin
            hm17 = hs;
        end
        hm = hm17[14:0];
        hv = {hm, {B{1'b0}}} + (15 + B)'(TURN_HALF);

        // sine and cosine from the quarter table
        idx  = r_acc[RECIP_SH +: B];
        cidx = idx + B'(TblQ);
        r0   = idx[B-3:0];
        r1   = cidx[B-3:0];
        v0   = idx[B-2]  ? w_qsin[TblQ - int'(r0)] : w_qsin[r0];
        v1   = cidx[B-2] ? w_qsin[TblQ - int'(r1)] : w_qsin[r1];

        tr      = -((48'(r_acc) + 48'sd32768) >>> 16);
        aturn   = r_turn[15] ? 15'(-r_turn) : r_turn[14:0];
        rx      = {1'b0, aturn, 1'b0} + 17'd2;
        q       = r_acc[RECIP5_SH +: 14];
        tfin    = r_turn[15] ? $signed({2'b0, q}) : -$signed({2'b0, q});
        aligned = r_abs_e < {1'b0, r_align};

        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !r_lc_pend) begin
                    n_e     = 17'(i_in_data.goal_heading) - 17'(i_in_data.heading);
                    n_diff  = 18'(n_e) - 18'(r_last);
                    n_last  = n_e;
                    n_abs_e = n_e[16] ? 16'(-n_e) : n_e[15:0];
                    n_ex    = 17'(i_in_data.goal_x) - 17'(i_in_data.pos_x);
                    n_ey    = 17'(i_in_data.goal_y) - 17'(i_in_data.pos_y);
                    n_w     = hv[14+B:9];
                    n_state = S_TURN_P;
                end
            end
            S_TURN_P: begin
                w_mul_a  = 35'(r_e);
                w_mul_b  = $signed({1'b0, 25'(r_hp) + 25'(r_hi)});
                w_acc_op = ACC_LOAD;
                n_state  = S_TURN_D;
            end
            S_TURN_D: begin
                w_mul_a  = 35'(r_diff);
                w_mul_b  = $signed({2'b0, r_hd});
                w_acc_op = ACC_ADD;
                n_state  = S_TURN_R;
            end
            S_TURN_R: begin
                n_turn   = clamp16(tr, r_lim);
                w_mul_a  = $signed({{(35-WW){1'b0}}, r_w});
                w_mul_b  = $signed({5'b0, RECIP_45});
                w_acc_op = ACC_LOAD;
                n_state  = S_LOOK;
            end
            S_LOOK: begin
                n_sn    = idx[B-1]  ? -$signed({1'b0, v0}) : $signed({1'b0, v0});
                n_cs    = cidx[B-1] ? -$signed({1'b0, v1}) : $signed({1'b0, v1});
                n_state = S_FE_C;
            end
            S_FE_C: begin
                w_mul_a  = 35'(r_ex);
                w_mul_b  = 26'(r_cs);
                w_acc_op = ACC_LOAD;
                n_state  = S_FE_S;
            end
            S_FE_S: begin
                w_mul_a  = 35'(r_ey);
                w_mul_b  = 26'(r_sn);
                w_acc_op = ACC_ADD;
                n_state  = S_LE_C;
            end
            S_LE_C: begin
                n_fe     = r_acc[32:0];
                w_mul_a  = 35'(r_ey);
                w_mul_b  = 26'(r_cs);
                w_acc_op = ACC_LOAD;
                n_state  = S_LE_S;
            end
            S_LE_S: begin
                w_mul_a  = 35'(r_ex);
                w_mul_b  = 26'(r_sn);
                w_acc_op = ACC_SUB;
                n_state  = S_FWD;
            end
            S_FWD: begin
                n_le     = r_acc[32:0];
                w_mul_a  = 35'(r_fe);
                w_mul_b  = $signed({2'b0, r_fg});
                w_acc_op = ACC_LOAD;
                n_state  = S_LAT;
            end
            S_LAT: begin
                n_fc     = clamp16(48'((r_acc + 61'sd536870912) >>> 30), r_lim);
                w_mul_a  = 35'(r_le);
                w_mul_b  = $signed({2'b0, r_lg});
                w_acc_op = ACC_LOAD;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // rounded 2t/5 for the wrap case, computed on the last pass
                if (!(r_out_valid && i_out_stall)) begin
                    n_lc     = clamp16(48'((r_acc + 61'sd536870912) >>> 30), r_lim);
                    w_mul_a  = $signed({18'b0, rx});
                    w_mul_b  = $signed({9'b0, RECIP_5});
                    w_acc_op = ACC_LOAD;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // result register is loaded in idle while the pending flag is set, after r_lc is registered
        if (r_state == S_IDLE && r_lc_pend) begin
            n_out.turn_rate   = (r_abs_e > {1'b0, r_wrap}) ? tfin : r_turn;
            n_out.forward_cmd = aligned ? r_fc : 16'sd0;
            n_out.lateral_cmd = aligned ? r_lc : 16'sd0;
            n_out.aligned     = aligned;
            n_out_valid       = 1'b1;
        end
    end

    assign n_lc_pend = (r_state == S_DONE) && !(r_out_valid && i_out_stall);

    always_comb begin
        case (w_acc_op)
            ACC_LOAD: n_acc = w_prod;
            ACC_ADD:  n_acc = r_acc + w_prod;
            ACC_SUB:  n_acc = r_acc - w_prod;
            default:  n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            r_lc_pend   <= 1'b0;
            r_hp        <= RST_HEAD_P;
            r_hi        <= RST_HEAD_I;
            r_hd        <= RST_HEAD_D;
            r_fg        <= RST_FWD;
            r_lg        <= RST_LAT;
            r_lim       <= RST_LIMIT;
            r_wrap      <= RST_WRAP;
            r_align     <= RST_ALIGN;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            r_lc_pend   <= n_lc_pend;
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_HEAD_P: r_hp    <= i_cfg_data;
                    CFG_HEAD_I: r_hi    <= i_cfg_data;
                    CFG_HEAD_D: r_hd    <= i_cfg_data;
                    CFG_FWD:    r_fg    <= i_cfg_data;
                    CFG_LAT:    r_lg    <= i_cfg_data;
                    CFG_LIMIT:  r_lim   <= i_cfg_data[LIM_W-1:0];
                    CFG_WRAP:   r_wrap  <= i_cfg_data[LIM_W-1:0];
                    CFG_ALIGN:  r_align <= i_cfg_data[LIM_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_e     <= n_e;
        r_diff  <= n_diff;
        r_ex    <= n_ex;
        r_ey    <= n_ey;
        r_abs_e <= n_abs_e;
        r_w     <= n_w;
        r_acc   <= n_acc;
        r_turn  <= n_turn;
        r_sn    <= n_sn;
        r_cs    <= n_cs;
        r_fe    <= n_fe;
        r_le    <= n_le;
        r_fc    <= n_fc;
        r_lc    <= n_lc;
        r_out   <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE) || r_lc_pend;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted but sequencer not busy");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_lc_pend))
        else $error("result appeared without finishing a request");

    a_gate_translation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.aligned) |->
            (o_out_data.forward_cmd == 16'sd0 && o_out_data.lateral_cmd == 16'sd0))
        else $error("translation command while not aligned");

endmodule
